FILE: src/cwb_pkg.sv
package cwb_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    localparam int POS_W  = 16;
    localparam int LAT_W  = 16;
    localparam int KIND_W = 2;
    localparam int REG_W  = 16;
    localparam int REGI_W = 2;

    localparam logic [KIND_W-1:0] KIND_STORE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [REGI_W-1:0] REG_DEFAULT_LOW  = 2'd0;
    localparam logic [REGI_W-1:0] REG_DEFAULT_HIGH = 2'd1;
    localparam logic [REGI_W-1:0] REG_WINDOW_LEN   = 2'd2;

    localparam logic signed [LAT_W-1:0] RST_DEFAULT_LOW  = -16'sd2560;
    localparam logic signed [LAT_W-1:0] RST_DEFAULT_HIGH = 16'sd2560;
    localparam logic [POS_W-1:0]        RST_WINDOW_LEN   = 16'd256;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic latch;
        logic exec;
        logic rd_issue;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic             is_query;
        logic             cnt_zero;
        logic             last_rd;
        logic             out_free;
    } t_sts;

endpackage

FILE: src/cwb_ram.sv
module cwb_ram
    #(
        parameter int WIDTH = 48,
        parameter int DEPTH = 256
    )
    (
        input  logic                     i_clk,
        input  logic                     i_we,
        input  logic [$clog2(DEPTH)-1:0] i_waddr,
        input  logic [WIDTH-1:0]         i_wdata,
        input  logic [$clog2(DEPTH)-1:0] i_raddr,
        output logic [WIDTH-1:0]         o_rdata
    );

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/cwb_ctrl.sv
module cwb_ctrl
    import cwb_pkg::*;
    (
        input  logic i_clk,
        input  logic i_rst_n,
        input  logic i_valid,
        input  t_sts i_sts,
        output logic o_stall,
        output t_cmd o_cmd
    );

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.is_query && !i_sts.cnt_zero) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SCAN: begin
                o_cmd.rd_issue = 1'b1;
                if (i_sts.last_rd) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last read word is folded in this cycle
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/cwb_dp.sv
module cwb_dp
    import cwb_pkg::*;
    #(
        parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
    )
    (
        input  logic                     i_clk,
        input  logic                     i_rst_n,
        input  t_cmd                     i_cmd,
        output t_sts                     o_sts,
        input  logic                     i_cfg_we,
        input  logic [REGI_W-1:0]        i_cfg_index,
        input  logic [REG_W-1:0]         i_cfg_data,
        input  logic [KIND_W-1:0]        i_kind,
        input  logic [POS_W-1:0]         i_position,
        input  logic signed [LAT_W-1:0]  i_sample_low,
        input  logic signed [LAT_W-1:0]  i_sample_high,
        input  logic                     i_stall,
        output logic                     o_valid,
        output logic signed [LAT_W-1:0]  o_corridor_low,
        output logic signed [LAT_W-1:0]  o_corridor_high,
        output logic                     o_limited,
        output logic                     o_status
    );

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int DW  = POS_W + 2 * LAT_W;

    // configuration
    logic signed [LAT_W-1:0] r_def_low;
    logic signed [LAT_W-1:0] r_def_high;
    logic [POS_W-1:0]        r_win;

    // held item
    logic [KIND_W-1:0]       r_kind;
    logic [POS_W-1:0]        r_pos;
    logic signed [LAT_W-1:0] r_slo;
    logic signed [LAT_W-1:0] r_shi;
    logic [POS_W:0]          r_end;

    // table control
    logic [CW-1:0]           r_count;
    logic [AW-1:0]           r_idx;
    logic                    r_rd_vld;

    // working result
    logic signed [LAT_W-1:0] r_lo;
    logic signed [LAT_W-1:0] r_hi;
    logic                    r_lim;
    logic                    r_sts;

    // output word
    logic                    r_o_valid;
    logic signed [LAT_W-1:0] r_o_lo;
    logic signed [LAT_W-1:0] r_o_hi;
    logic                    r_o_lim;
    logic                    r_o_sts;

    logic                    full;
    logic                    wr_en;
    logic [DW-1:0]           wr_data;
    logic [DW-1:0]           rd_data;
    logic [POS_W-1:0]        rd_pos;
    logic signed [LAT_W-1:0] rd_lo;
    logic signed [LAT_W-1:0] rd_hi;
    logic                    hit;

    assign full    = (r_count == CW'(TABLE_DEPTH));
    assign wr_en   = i_cmd.exec && (r_kind == KIND_STORE) && !full;
    assign wr_data = {r_pos, r_slo, r_shi};

    cwb_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wr_data),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    assign rd_pos = rd_data[DW-1 -: POS_W];
    assign rd_lo  = $signed(rd_data[2*LAT_W-1 -: LAT_W]);
    assign rd_hi  = $signed(rd_data[LAT_W-1:0]);
    assign hit    = r_rd_vld && (rd_pos > r_pos) && ({1'b0, rd_pos} < r_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_low  <= RST_DEFAULT_LOW;
            r_def_high <= RST_DEFAULT_HIGH;
            r_win      <= RST_WINDOW_LEN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DEFAULT_LOW:  r_def_low  <= $signed(i_cfg_data);
                REG_DEFAULT_HIGH: r_def_high <= $signed(i_cfg_data);
                REG_WINDOW_LEN:   r_win      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind <= i_kind;
            r_pos  <= i_position;
            r_slo  <= i_sample_low;
            r_shi  <= i_sample_high;
            r_end  <= {1'b0, i_position} + {1'b0, r_win};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_issue;
            if (wr_en) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.exec && (r_kind == KIND_CLEAR)) begin
                r_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_idx <= '0;
        end else if (i_cmd.rd_issue) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_lim <= 1'b0;
            r_sts <= (r_kind == KIND_STORE) && full;
            if (r_kind == KIND_QUERY) begin
                r_lo <= r_def_low;
                r_hi <= r_def_high;
            end else begin
                r_lo <= '0;
                r_hi <= '0;
            end
        end else if (hit) begin
            r_lim <= 1'b1;
            if (rd_lo > r_lo) begin
                r_lo <= rd_lo;
            end
            if (rd_hi < r_hi) begin
                r_hi <= rd_hi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_lo  <= r_lo;
            r_o_hi  <= r_hi;
            r_o_lim <= r_lim;
            r_o_sts <= r_sts;
        end
    end

    assign o_sts.is_query = (r_kind == KIND_QUERY);
    assign o_sts.cnt_zero = (r_count == '0);
    assign o_sts.last_rd  = (CW'(r_idx) == r_count - CW'(1));
    assign o_sts.out_free = !r_o_valid || !i_stall;

    assign o_valid         = r_o_valid;
    assign o_corridor_low  = r_o_lo;
    assign o_corridor_high = r_o_hi;
    assign o_limited       = r_o_lim;
    assign o_status        = r_o_sts;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("sample count beyond table depth");

    a_read_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_issue |-> (CW'(r_idx) < r_count))
        else $error("scan reads past the filled part of the table");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> o_sts.out_free)
        else $error("result loaded over a word still waiting");

    a_drop_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_kind == KIND_STORE) && full) |=> (r_sts && $stable(r_count)))
        else $error("store into full table not flagged or not dropped");
`endif

endmodule

FILE: src/corridor_window_bounds.sv
// Corridor window bounds: a table of obstacle samples (path position,
// lateral low and high bound, Q8) and a corridor lookup over it.
// Input channel: i_valid / o_stall with i_kind, i_position, i_sample_low,
// i_sample_high. Kind store appends a sample (dropped with status set when
// the table is full), kind clear empties the table, kind query returns the
// defaults narrowed by every sample with query < position < query + window.
// Output channel: o_valid / i_stall, exactly one word per input word.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 default low, 1 default high, 2 window length); write only when idle.
// After accept, store, clear and unused kinds pass through EXEC to DONE;
// a query with N stored samples passes EXEC, SCAN over the N entries, DRAIN
// and DONE (EXEC straight to DONE with an empty table), and the scan reads
// the single sample RAM one entry per cycle. A new word is accepted in the
// cycle after the previous result is handed to the output register.
// The output register lets the next word be taken while a result waits;
// a stalled result holds and the block waits in its final state.
// Reset (synchronous, active low) empties the table, restores the register
// defaults and drops any pending result; the RAM needs no clearing pass.
module corridor_window_bounds
    import cwb_pkg::*;
    #(
        parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
    )
    (
        input  logic                    i_clk,
        input  logic                    i_rst_n,
        input  logic                    i_cfg_we,
        input  logic [REGI_W-1:0]       i_cfg_index,
        input  logic [REG_W-1:0]        i_cfg_data,
        input  logic                    i_valid,
        output logic                    o_stall,
        input  logic [KIND_W-1:0]       i_kind,
        input  logic [POS_W-1:0]        i_position,
        input  logic signed [LAT_W-1:0] i_sample_low,
        input  logic signed [LAT_W-1:0] i_sample_high,
        output logic                    o_valid,
        input  logic                    i_stall,
        output logic signed [LAT_W-1:0] o_corridor_low,
        output logic signed [LAT_W-1:0] o_corridor_high,
        output logic                    o_limited,
        output logic                    o_status
    );

    t_cmd cmd;
    t_sts sts;

    cwb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    cwb_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_kind),
        .i_position      (i_position),
        .i_sample_low    (i_sample_low),
        .i_sample_high   (i_sample_high),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_corridor_low  (o_corridor_low),
        .o_corridor_high (o_corridor_high),
        .o_limited       (o_limited),
        .o_status        (o_status)
    );

endmodule

FILE: sim/tb_corridor_window_bounds.sv
`default_nettype none

module tb_corridor_window_bounds;
    import cwb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = TABLE_DEPTH_DEF;
    localparam int ITEM_TARGET = 1650;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int PRINT_CAP   = 200;

    // codes the package leaves unnamed
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [REGI_W-1:0] REG_UNUSED  = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  position;
        logic [LAT_W-1:0]  low;
        logic [LAT_W-1:0]  high;
    } t_word;

    typedef struct packed {
        logic [LAT_W-1:0] low;
        logic [LAT_W-1:0] high;
        logic             limited;
        logic             status;
    } t_corridor;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [REGI_W-1:0]       i_cfg_index;
    logic [REG_W-1:0]        i_cfg_data;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [KIND_W-1:0]       i_kind = KIND_CLEAR;
    logic [POS_W-1:0]        i_position = '0;
    logic signed [LAT_W-1:0] i_sample_low = '0;
    logic signed [LAT_W-1:0] i_sample_high = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b1;
    logic signed [LAT_W-1:0] o_corridor_low;
    logic signed [LAT_W-1:0] o_corridor_high;
    logic                    o_limited;
    logic                    o_status;

    corridor_window_bounds dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_position     (i_position),
        .i_sample_low   (i_sample_low),
        .i_sample_high  (i_sample_high),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_corridor_low (o_corridor_low),
        .o_corridor_high(o_corridor_high),
        .o_limited      (o_limited),
        .o_status       (o_status)
    );

    // predictor state: obstacle table and register copies
    logic [POS_W-1:0] obst_pos  [DEPTH];
    logic [LAT_W-1:0] obst_low  [DEPTH];
    logic [LAT_W-1:0] obst_high [DEPTH];
    int               obst_count = 0;
    logic [LAT_W-1:0] lim_low    = RST_DEFAULT_LOW;
    logic [LAT_W-1:0] lim_high   = RST_DEFAULT_HIGH;
    logic [POS_W-1:0] look_ahead = RST_WINDOW_LEN;

    t_word     queued_words[$];
    t_corridor corridors_due[$];

    int  error_count = 0;
    int  items_sent  = 0;
    int  result_no   = 0;
    int  cycle_count = 0;
    int  tx_wait     = 0;
    int  rx_wait     = 0;
    int  hold_left   = 0;
    int  hold_req    = 0;
    int  hold_seen   = 0;
    bit  fast_mode   = 1'b0;
    bit  in_taken    = 1'b0;
    bit  out_taken   = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string msg);
        if (error_count < PRINT_CAP)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // apply one word to the table copy and return the corridor it yields
    function automatic t_corridor corridor_step(input t_word w);
        t_corridor   r;
        logic [16:0] reach;
        r = '0;
        case (w.kind)
            KIND_STORE: begin
                if (obst_count < DEPTH) begin
                    obst_pos[obst_count]  = w.position;
                    obst_low[obst_count]  = w.low;
                    obst_high[obst_count] = w.high;
                    obst_count++;
                end else begin
                    r.status = 1'b1;
                end
            end
            KIND_QUERY: begin
                // open interval, end formed in 17 bits so it never wraps
                reach  = {1'b0, w.position} + {1'b0, look_ahead};
                r.low  = lim_low;
                r.high = lim_high;
                for (int i = 0; i < obst_count; i++) begin
                    if (obst_pos[i] > w.position && {1'b0, obst_pos[i]} < reach) begin
                        if ($signed(obst_low[i]) > $signed(r.low))
                            r.low = obst_low[i];
                        if ($signed(obst_high[i]) < $signed(r.high))
                            r.high = obst_high[i];
                        r.limited = 1'b1;
                    end
                end
            end
            KIND_CLEAR: begin
                obst_count = 0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // sample both handshakes; check results, then predict accepted words
    always @(posedge i_clk) begin : watch
        t_word     w;
        t_corridor want;
        cycle_count++;
        in_taken  = 1'b0;
        out_taken = 1'b0;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                out_taken = 1'b1;
                if (corridors_due.size() == 0) begin
                    flag_mismatch($sformatf("result with nothing due: low %0d high %0d lim %0b st %0b",
                        o_corridor_low, o_corridor_high, o_limited, o_status));
                end else begin
                    want = corridors_due.pop_front();
                    if (o_corridor_low !== want.low)
                        flag_mismatch($sformatf("result %0d corridor_low %0d, want %0d",
                            result_no, o_corridor_low, $signed(want.low)));
                    if (o_corridor_high !== want.high)
                        flag_mismatch($sformatf("result %0d corridor_high %0d, want %0d",
                            result_no, o_corridor_high, $signed(want.high)));
                    if (o_limited !== want.limited)
                        flag_mismatch($sformatf("result %0d limited %0b, want %0b",
                            result_no, o_limited, want.limited));
                    if (o_status !== want.status)
                        flag_mismatch($sformatf("result %0d status %0b, want %0b",
                            result_no, o_status, want.status));
                end
                result_no++;
            end
            if (i_valid && !o_stall) begin
                in_taken   = 1'b1;
                w.kind     = i_kind;
                w.position = i_position;
                w.low      = i_sample_low;
                w.high     = i_sample_high;
                want       = corridor_step(w);
                corridors_due.insert(corridors_due.size(), want);
            end
        end
    end

    // sender: hold a word until taken, then idle for a drawn gap
    always @(negedge i_clk) begin : send
        logic  nv;
        t_word w;
        nv = i_valid;
        if (in_taken)
            nv = 1'b0;
        if (!nv) begin
            if (tx_wait > 0) begin
                tx_wait--;
            end else if (queued_words.size() != 0) begin
                w             = queued_words.pop_front();
                i_kind        <= w.kind;
                i_position    <= w.position;
                i_sample_low  <= w.low;
                i_sample_high <= w.high;
                nv            = 1'b1;
                tx_wait       = fast_mode ? 0 : $urandom_range(0, 5);
            end
        end
        i_valid <= nv;
    end

    // receiver: drawn stall per word, plus the occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (out_taken)
            rx_wait = fast_mode ? 0 : $urandom_range(0, 5);
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            if (o_valid)
                rx_wait--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic logic [15:0] rand16();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [15:0] rand_lat();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 16'h8000;
        if (r == 1)
            return 16'h7FFF;
        if (r == 2)
            return 16'h0000;
        if (r < 9)
            return rand16();
        return 16'($urandom_range(0, 8192) - 4096);
    endfunction

    function automatic logic [15:0] near(input int base, input int span);
        return 16'(base + int'($urandom_range(0, span)) - span / 2);
    endfunction

    task automatic queue_word(input logic [KIND_W-1:0] kind, input logic [15:0] pos,
                              input logic [15:0] lo, input logic [15:0] hi);
        t_word w;
        w.kind     = kind;
        w.position = pos;
        w.low      = lo;
        w.high     = hi;
        queued_words.insert(queued_words.size(), w);
        if (kind != KIND_UNUSED)
            items_sent++;
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        while (queued_words.size() != 0 || i_valid || corridors_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [15:0] lo, input logic [15:0] hi,
                                 input logic [15:0] win, input bit poke_unused);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_DEFAULT_LOW;
        i_cfg_data  <= lo;
        @(negedge i_clk);
        i_cfg_index <= REG_DEFAULT_HIGH;
        i_cfg_data  <= hi;
        @(negedge i_clk);
        i_cfg_index <= REG_WINDOW_LEN;
        i_cfg_data  <= win;
        if (poke_unused) begin
            // out-of-range index: must leave every register alone
            @(negedge i_clk);
            i_cfg_index <= REG_UNUSED;
            i_cfg_data  <= rand16();
        end
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        lim_low    = lo;
        lim_high   = hi;
        look_ahead = win;
    endtask

    task automatic run_phase(input int phase_no);
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] win;
        bit          fill;
        int          span;
        int          base;
        int          n;
        int          r;
        wait_idle();
        fill = (phase_no == 0) || ($urandom_range(0, 13) == 0);
        case (phase_no)
            0: begin
                lo = 16'h8000; hi = 16'h7FFF; win = 16'hFFFF;
            end
            1: begin
                lo = 16'h7FFF; hi = 16'h8000; win = 16'h0000;
            end
            2: begin
                lo = 16'h0000; hi = 16'h0000; win = 16'h0001;
            end
            default: begin
                r  = $urandom_range(0, 5);
                lo = (r == 0) ? 16'h8000 : (r == 1) ? 16'h7FFF :
                     16'(-int'($urandom_range(0, 4096)));
                r  = $urandom_range(0, 5);
                hi = (r == 0) ? 16'h7FFF : (r == 1) ? 16'h8000 :
                     16'($urandom_range(0, 4096));
                r  = $urandom_range(0, 9);
                win = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : (r == 2) ? 16'h0001 :
                      16'($urandom_range(2, 3000));
            end
        endcase
        load_settings(lo, hi, win, phase_no == 2 || $urandom_range(0, 9) == 0);

        @(posedge i_clk);
        fast_mode = ($urandom_range(0, 3) == 0);
        if (phase_no == 1 || $urandom_range(0, 11) == 0) begin
            // keep offering while the receiver holds off, so the input backs up
            fast_mode = 1'b1;
            hold_req++;
        end

        span = 2 * int'(win) + 4;
        if (span > 65535)
            span = 65535;
        base = $urandom_range(0, 65535);

        if (fill || $urandom_range(0, 3) != 0)
            queue_word(KIND_CLEAR, rand16(), rand16(), rand16());
        n = fill ? DEPTH + $urandom_range(1, 4) : $urandom_range(0, 24);
        for (int i = 0; i < n; i++)
            queue_word(KIND_STORE, near(base, span), rand_lat(), rand_lat());

        n = fill ? $urandom_range(8, 16) : $urandom_range(10, 40);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 19);
            if (r < 12)
                queue_word(KIND_QUERY, near(base, span), rand16(), rand16());
            else if (r < 16)
                queue_word(KIND_STORE, near(base, span), rand_lat(), rand_lat());
            else if (r == 16)
                queue_word(KIND_CLEAR, rand16(), rand16(), rand16());
            else if (r == 17)
                queue_word(KIND_UNUSED, rand16(), rand16(), rand16());
            else if (r == 18)
                queue_word(KIND_QUERY, rand16(), rand16(), rand16());
            else
                queue_word(KIND_STORE, rand16(), rand16(), rand16());
        end
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int phase_no;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_DEFAULT_LOW;
        i_cfg_data  = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: -10 m .. +10 m, window 1 m
        queue_word(KIND_QUERY,  16'h0000, 16'h0000, 16'h0000);  // empty table
        queue_word(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_word(KIND_STORE,  16'h0001, 16'h8000, 16'h7FFF);
        queue_word(KIND_STORE,  16'h00FF, 16'h7FFF, 16'h8000);  // crossed bounds
        queue_word(KIND_STORE,  16'hFFFF, 16'h5555, 16'hAAAA);
        queue_word(KIND_STORE,  16'h0000, 16'hAAAA, 16'h5555);
        queue_word(KIND_STORE,  16'h0100, 16'h0000, 16'h0000);  // right on the window end
        queue_word(KIND_QUERY,  16'h0000, 16'h0000, 16'h0000);
        queue_word(KIND_QUERY,  16'h0001, 16'hFFFF, 16'hFFFF);
        queue_word(KIND_QUERY,  16'hFF00, 16'h0000, 16'h0000);
        queue_word(KIND_QUERY,  16'hFFFE, 16'h0000, 16'h0000);
        queue_word(KIND_QUERY,  16'hFFFF, 16'h0000, 16'h0000);  // nothing above the top
        queue_word(KIND_CLEAR,  16'hFFFF, 16'h7FFF, 16'h8000);
        queue_word(KIND_QUERY,  16'h0000, 16'h0000, 16'h0000);
        queue_word(KIND_STORE,  16'h0002, 16'hF700, 16'h0A00);
        queue_word(KIND_QUERY,  16'h0001, 16'h0000, 16'h0000);
        queue_word(KIND_UNUSED, 16'h0000, 16'h0000, 16'h0000);

        phase_no = 0;
        while (items_sent < ITEM_TARGET) begin
            run_phase(phase_no);
            phase_no++;
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (corridors_due.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", corridors_due.size()));
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
